FILE: src/smrf_pkg.sv
// Shared types and constants for the sliding median row filter.
`default_nettype none
package smrf_pkg;

	localparam int DEFAULT_WINDOW    = 50;
	localparam int DEFAULT_MAX_WIDTH = 4096;

	localparam int PIX_W     = 8;
	localparam int ROW_W     = 13;
	localparam int CENTER_W  = 12;

	localparam logic [ROW_W-1:0] ROW_WIDTH_RESET = 13'd640;

	typedef logic [PIX_W-1:0] pix_t;

	// What one cell shows its neighbors.
	typedef struct packed {
		pix_t value; // sorted entry held by the cell
		pix_t delay; // arrival line entry held by the cell
		logic lt;    // entry is valid and below the pixel leaving the window
		logic le;    // entry is valid and not above the incoming pixel
	} smrf_link_t;

	// Values broadcast to every cell for the item being taken.
	typedef struct packed {
		pix_t in_pix;  // incoming pixel
		pix_t old_pix; // pixel leaving the window
		logic old_le;  // leaving pixel is not above the incoming pixel
		logic remove;  // window is full, one entry leaves
		logic shift;   // an item is accepted this cycle
	} smrf_bcast_t;

endpackage
`default_nettype wire

FILE: src/smrf_cell.sv
// One cell of the sorted window chain: a sorted entry and an arrival line entry.
`default_nettype none
module smrf_cell #(
	parameter int NW  = 6,
	parameter int IDX = 0
) (
	input  wire logic                clk,
	input  wire smrf_pkg::smrf_link_t left,
	input  wire smrf_pkg::smrf_link_t right,
	input  wire smrf_pkg::smrf_bcast_t bc,
	input  wire logic [NW-1:0]       fill,
	output smrf_pkg::smrf_link_t     link,
	output smrf_pkg::pix_t           next_value
);

	smrf_pkg::pix_t value_q;
	smrf_pkg::pix_t delay_q;
	logic           valid;
	logic           from_left;

	assign valid = NW'(IDX) < fill;

	assign link.value = value_q;
	assign link.delay = delay_q;
	assign link.lt    = valid && (value_q < bc.old_pix);
	assign link.le    = valid && (value_q <= bc.in_pix);

	// While the window fills nothing leaves, so every entry above the
	// insertion point moves up by one.
	assign from_left = !bc.remove || left.lt;

	always_comb begin
		next_value = value_q;
		if (bc.remove && bc.old_le) begin
			// Leaving entry sits at or below the insertion point: the span
			// between them moves down and the new pixel lands on top of it.
			if (link.lt) begin
				next_value = value_q;
			end else if (right.le) begin
				next_value = right.value;
			end else if (link.le) begin
				next_value = bc.in_pix;
			end
		end else begin
			if (link.le) begin
				next_value = value_q;
			end else if (left.le) begin
				next_value = bc.in_pix;
			end else if (from_left) begin
				next_value = left.value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bc.shift) begin
			value_q <= next_value;
			delay_q <= left.delay;
		end
	end

endmodule
`default_nettype wire

FILE: src/sliding_median_row_filter_core.sv
// Top level of the sliding median row filter: cell chain, column counter, output register.
// The block takes one 8-bit gray pixel per item in row order and keeps, in a chain of
// WINDOW cells, both an exactly sorted copy of the last WINDOW pixels of the current row
// and a delay line of the same pixels in arrival order. Each accepted pixel updates every
// cell at once in the clock edge that takes it: the pixel leaving the window is removed and
// the new one is inserted after any equal entries, with each cell deciding from its own
// compares and those of its two neighbors. From column WINDOW-1 of a row onward, each pixel
// yields one result item carrying the upper median (sorted entry WINDOW/2) and the column
// it belongs to (current column minus WINDOW/2); earlier columns yield nothing, and the
// window starts empty at every row. One item is taken per clock; the result shows up in
// the output register on the following cycle. The output register is the only buffer, so
// the pixel channel stalls exactly while a result is held there and the downstream side
// stalls. The row width register is written through its own channel, which is always ready;
// widths above MAX_WIDTH count as MAX_WIDTH and a width of zero counts as one. No clearing
// pass is needed after reset: the block can take a pixel in the first cycle.
`default_nettype none
module sliding_median_row_filter_core #(
	parameter int WINDOW    = smrf_pkg::DEFAULT_WINDOW,
	parameter int MAX_WIDTH = smrf_pkg::DEFAULT_MAX_WIDTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        pixel_valid,
	output logic                             pixel_stall,
	input  wire logic [smrf_pkg::PIX_W-1:0]  pixel,
	output logic                             median_valid,
	input  wire logic                        median_stall,
	output logic [smrf_pkg::PIX_W-1:0]       median_value,
	output logic [smrf_pkg::CENTER_W-1:0]    center_column,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [smrf_pkg::ROW_W-1:0]  cfg_data
);

	// Fill count width, column counter width, and a compare width that holds
	// the counter, the window size and the row width register with room to spare.
	localparam int NW = $clog2(WINDOW + 1);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int MW = (CW > NW) ? CW : NW;
	localparam int XW = ((MW > smrf_pkg::ROW_W) ? MW : smrf_pkg::ROW_W) + 1;

	logic [smrf_pkg::ROW_W-1:0]    row_width_q;
	logic [CW-1:0]                 col_q;
	logic                          median_valid_q;
	smrf_pkg::pix_t                median_value_q;
	logic [smrf_pkg::CENTER_W-1:0] center_column_q;

	logic [XW-1:0]  col_x;
	logic [XW-1:0]  width_x;
	logic [XW-1:0]  width_eff;
	logic [XW-1:0]  center_x;
	logic [NW-1:0]  fill;
	logic           full;
	logic           emit;
	logic           row_end;
	logic           accept;

	smrf_pkg::smrf_bcast_t bc;
	smrf_pkg::smrf_link_t  cell_link [WINDOW];
	smrf_pkg::pix_t        cell_next [WINDOW];
	smrf_pkg::smrf_link_t  left_edge;
	smrf_pkg::smrf_link_t  right_edge;

	// The output register is the only buffer, so a held and stalled result
	// blocks the pixel channel.
	assign pixel_stall = median_valid_q && median_stall;
	assign accept      = pixel_valid && !pixel_stall;
	assign cfg_ready   = 1'b1;

	assign col_x   = {{(XW-CW){1'b0}}, col_q};
	assign width_x = {{(XW-smrf_pkg::ROW_W){1'b0}}, row_width_q};

	always_comb begin
		width_eff = width_x;
		if (width_x > XW'(MAX_WIDTH)) begin
			width_eff = XW'(MAX_WIDTH);
		end else if (width_x == '0) begin
			width_eff = XW'(1);
		end
	end

	// The window holds min(column, WINDOW) entries of the current row.
	assign full     = col_x >= XW'(WINDOW);
	assign fill     = full ? NW'(WINDOW) : col_x[NW-1:0];
	assign emit     = col_x >= XW'(WINDOW - 1);
	assign row_end  = (col_x + XW'(1)) >= width_eff;
	assign center_x = col_x - XW'(WINDOW / 2);

	// The pixel leaving the window is the tail of the arrival line; once the
	// window is full it is exactly WINDOW pixels back in the same row.
	assign bc.in_pix  = pixel;
	assign bc.old_pix = cell_link[WINDOW-1].delay;
	assign bc.old_le  = cell_link[WINDOW-1].delay <= pixel;
	assign bc.remove  = full;
	assign bc.shift   = accept;

	// Boundary neighbors: nothing sits below the first cell, nothing valid
	// sits above the last one. The first cell feeds the arrival line.
	assign left_edge.value  = '0;
	assign left_edge.delay  = pixel;
	assign left_edge.lt     = 1'b1;
	assign left_edge.le     = 1'b1;
	assign right_edge.value = '0;
	assign right_edge.delay = '0;
	assign right_edge.lt    = 1'b0;
	assign right_edge.le    = 1'b0;

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		smrf_cell #(
			.NW  (NW),
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.left       ((i == 0) ? left_edge : cell_link[(i == 0) ? 0 : i-1]),
			.right      ((i == WINDOW-1) ? right_edge
				: cell_link[(i == WINDOW-1) ? WINDOW-1 : i+1]),
			.bc         (bc),
			.fill       (fill),
			.link       (cell_link[i]),
			.next_value (cell_next[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= smrf_pkg::ROW_WIDTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			row_width_q <= cfg_data;
		end
	end

	// Column counter wraps to zero after the last pixel of a row, which also
	// empties the window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (accept) begin
			col_q <= row_end ? '0 : col_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			median_valid_q <= 1'b0;
		end else if (accept && emit) begin
			median_valid_q <= 1'b1;
		end else if (!median_stall) begin
			median_valid_q <= 1'b0;
		end
	end

	// The median is taken from the updated middle cell, so the result already
	// includes the pixel accepted in this cycle.
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			median_value_q  <= cell_next[WINDOW/2];
			center_column_q <= center_x[smrf_pkg::CENTER_W-1:0];
		end
	end

	assign median_valid  = median_valid_q;
	assign median_value  = median_value_q;
	assign center_column = center_column_q;

endmodule
`default_nettype wire

FILE: src/smrf_checker.sv
// Port-level assertions for the sliding median row filter, bound to the top level.
`default_nettype none
module smrf_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        pixel_valid,
	input wire logic                        pixel_stall,
	input wire logic                        median_valid,
	input wire logic                        median_stall,
	input wire logic [smrf_pkg::PIX_W-1:0]  median_value,
	input wire logic [smrf_pkg::CENTER_W-1:0] center_column
);

	// A held result that is stalled stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		median_valid && median_stall |=>
			median_valid && $stable(median_value) && $stable(center_column))
		else $error("stalled result item changed");

	// The pixel channel only stalls behind a held, stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> median_valid && median_stall)
		else $error("pixel channel stalled without a blocked result");

	// A new result needs an accepted pixel in the cycle before.
	a_rise_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(median_valid) |-> $past(pixel_valid && !pixel_stall))
		else $error("result item appeared without an accepted pixel");

	// A taken result with no new pixel leaves the output empty.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		median_valid && !median_stall && !(pixel_valid && !pixel_stall) |=> !median_valid)
		else $error("result item repeated");

endmodule

bind sliding_median_row_filter_core smrf_checker u_smrf_checker (.*);
`default_nettype wire
